// ----- design/assert_macros.svh -----
// assertion macros used by the tokenizer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define FT_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// property that must hold in the cycle after its trigger
`define FT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ----- design/ftok_pkg.sv -----
// types and constants shared by the tokenizer modules
`default_nettype none

package ftok_pkg;

  localparam int MAX_RESULTS = 3;
  localparam int CHAR_W      = 8;
  localparam int NUM_OUT_W   = 32;
  localparam int EVENT_W     = 3;
  localparam int TDATA_W     = CHAR_W + NUM_OUT_W;

  typedef enum logic [EVENT_W-1:0] {
    EV_WCH  = 3'd0,
    EV_SCH  = 3'd1,
    EV_WEND = 3'd2,
    EV_SEND = 3'd3,
    EV_NUM  = 3'd4,
    EV_BAD  = 3'd5,
    EV_EOL  = 3'd6
  } event_t;

  typedef struct packed {
    logic [1:0]                          count;
    event_t [MAX_RESULTS-1:0]            ev;
    logic [MAX_RESULTS-1:0][CHAR_W-1:0]  ch;
    logic [NUM_OUT_W-1:0]                num;
  } bundle_t;

endpackage

`default_nettype wire

// ----- design/ftok_lexer.sv -----
// lexer state and the per-byte decode that builds one bundle of results
`default_nettype none

module ftok_lexer #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int NUM_WIDTH     = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [7:0]             char_in,
  output ftok_pkg::bundle_t           bundle
);
  import ftok_pkg::*;

  localparam int TLEN_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [TLEN_W-1:0] TLEN_MAX = TLEN_W'(MAX_TOKEN_LEN);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [3:0] {
    M_IDLE, M_SKIP, M_BSLASH, M_SIGN, M_ZERO, M_ZEROX, M_NUM,
    M_WORD, M_STR, M_STRQ, M_ESC, M_ESCHEX, M_ESCOCT
  } mode_t;

  typedef enum logic [1:0] {RDX_DEC, RDX_OCT, RDX_HEX} radix_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [8:0] single_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:   r = {1'b1, 8'd7};
      8'h62:   r = {1'b1, 8'd8};
      8'h66:   r = {1'b1, 8'd12};
      8'h6e:   r = {1'b1, 8'd10};
      8'h72:   r = {1'b1, 8'd13};
      8'h74:   r = {1'b1, 8'd9};
      8'h76:   r = {1'b1, 8'd11};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h27:   r = {1'b1, 8'h27};
      8'h22:   r = {1'b1, 8'h22};
      8'h3f:   r = {1'b1, 8'h3f};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  mode_t                 mode, mode_next;
  logic [TLEN_W-1:0]     tlen, tlen_next;
  logic [NUM_WIDTH-1:0]  acc, acc_next;
  logic                  neg, neg_next;
  radix_t                radix, radix_next;
  logic [8:0]            escv, escv_next;
  logic [1:0]            escd, escd_next;

  logic                  is_end, is_ws, is_dec, is_oct;
  logic [4:0]            hv;
  logic [8:0]            sesc;
  logic [4:0]            base;
  logic                  digit_ok;
  logic [8:0]            escv_step;
  logic [1:0]            escd_step;
  logic [1:0]            cnt;
  logic                  do_word, do_fail, do_done, do_str;
  logic [7:0]            str_ch;
  logic [NUM_WIDTH-1:0]  mag;
  logic signed [NUM_WIDTH-1:0] sval;
  logic signed [63:0]    sval_ext;

  assign is_end = char_in == CH_NUL;
  assign is_ws  = char_in == CH_SPACE || (char_in >= 8'h09 && char_in <= 8'h0d);
  assign is_dec = char_in >= CH_ZERO && char_in <= CH_NINE;
  assign is_oct = char_in >= CH_ZERO && char_in <= CH_SEVEN;
  assign hv     = hex_val(char_in);
  assign sesc   = single_escape(char_in);

  always_comb begin
    case (radix)
      RDX_OCT: base = 5'd8;
      RDX_HEX: base = 5'd16;
      default: base = 5'd10;
    endcase
  end

  assign digit_ok = hv[4] && ({1'b0, hv[3:0]} < base);
  assign mag      = neg ? (~acc + NUM_WIDTH'(1)) : acc;
  assign sval     = mag;
  assign sval_ext = 64'(sval);

  always_comb begin
    mode_next  = mode;
    tlen_next  = tlen;
    acc_next   = acc;
    neg_next   = neg;
    radix_next = radix;
    escv_next  = escv;
    escd_next  = escd;
    cnt        = 2'd0;
    do_word    = 1'b0;
    do_fail    = 1'b0;
    do_done    = 1'b0;
    do_str     = 1'b0;
    str_ch     = 8'd0;
    escv_step  = 9'd0;
    escd_step  = 2'd0;
    bundle.ev  = {MAX_RESULTS{EV_WCH}};
    bundle.ch  = '0;
    bundle.num = sval_ext[NUM_OUT_W-1:0];

    case (mode)
      M_SKIP: begin
        if (is_end) begin
          mode_next = M_IDLE;
          tlen_next = '0;
          acc_next = '0;
          neg_next = 1'b0;
          radix_next = RDX_DEC;
          escv_next = 9'd0;
          escd_next = 2'd0;
          bundle.ev[cnt] = EV_EOL;
          cnt = cnt + 2'd1;
        end
      end
      M_BSLASH: begin
        if (char_in == CH_SPACE) begin
          mode_next = M_SKIP;
        end else begin
          bundle.ev[cnt] = EV_WCH;
          bundle.ch[cnt] = CH_BSL;
          cnt = cnt + 2'd1;
          mode_next = M_WORD;
          tlen_next = TLEN_W'(1);
          do_word = 1'b1;
        end
      end
      M_SIGN: begin
        if (is_dec) begin
          acc_next = NUM_WIDTH'(hv[3:0]);
          radix_next = RDX_DEC;
          mode_next = (char_in == CH_ZERO) ? M_ZERO : M_NUM;
        end else begin
          bundle.ev[cnt] = EV_WCH;
          bundle.ch[cnt] = neg ? CH_MINUS : CH_PLUS;
          cnt = cnt + 2'd1;
          neg_next = 1'b0;
          mode_next = M_WORD;
          tlen_next = TLEN_W'(1);
          do_word = 1'b1;
        end
      end
      M_ZERO: begin
        if (char_in == CH_X) begin
          mode_next = M_ZEROX;
        end else if (is_oct) begin
          radix_next = RDX_OCT;
          acc_next = NUM_WIDTH'(hv[3:0]);
          mode_next = M_NUM;
        end else if (is_end || is_ws) begin
          do_done = 1'b1;
        end else begin
          do_fail = 1'b1;
        end
      end
      M_ZEROX: begin
        if (!hv[4]) begin
          do_fail = 1'b1;
        end else begin
          radix_next = RDX_HEX;
          acc_next = NUM_WIDTH'(hv[3:0]);
          mode_next = M_NUM;
        end
      end
      M_NUM: begin
        if (is_end || is_ws) begin
          do_done = 1'b1;
        end else if (!digit_ok) begin
          do_fail = 1'b1;
        end else begin
          case (radix)
            RDX_OCT: acc_next = (acc << 3) + NUM_WIDTH'(hv[3:0]);
            RDX_HEX: acc_next = (acc << 4) + NUM_WIDTH'(hv[3:0]);
            default: acc_next = (acc << 3) + (acc << 1) + NUM_WIDTH'(hv[3:0]);
          endcase
        end
      end
      M_WORD: begin
        do_word = 1'b1;
      end
      M_STR: begin
        if (char_in == CH_QUOTE) begin
          mode_next = M_STRQ;
        end else if (is_end || tlen >= TLEN_MAX) begin
          do_fail = 1'b1;
        end else if (char_in == CH_BSL) begin
          mode_next = M_ESC;
        end else begin
          do_str = 1'b1;
          str_ch = char_in;
        end
      end
      M_STRQ: begin
        if (is_end || is_ws) begin
          bundle.ev[cnt] = EV_SEND;
          cnt = cnt + 2'd1;
          mode_next = M_IDLE;
          tlen_next = '0;
          acc_next = '0;
          neg_next = 1'b0;
          radix_next = RDX_DEC;
          escv_next = 9'd0;
          escd_next = 2'd0;
          if (is_end) begin
            bundle.ev[cnt] = EV_EOL;
            cnt = cnt + 2'd1;
          end
        end else begin
          do_fail = 1'b1;
        end
      end
      M_ESC: begin
        if (char_in == CH_X) begin
          escv_next = 9'd0;
          escd_next = 2'd0;
          mode_next = M_ESCHEX;
        end else if (is_oct) begin
          escv_next = {5'd0, hv[3:0]};
          escd_next = 2'd1;
          mode_next = M_ESCOCT;
        end else if (sesc[8]) begin
          do_str = 1'b1;
          str_ch = sesc[7:0];
        end else begin
          do_fail = 1'b1;
        end
      end
      M_ESCHEX: begin
        if (!hv[4]) begin
          do_fail = 1'b1;
        end else begin
          escv_step = {escv[4:0], hv[3:0]};
          escd_step = escd + 2'd1;
          escv_next = escv_step;
          escd_next = escd_step;
          if (escd_step >= 2'd2) begin
            do_str = 1'b1;
            str_ch = escv_step[7:0];
          end
        end
      end
      M_ESCOCT: begin
        if (!is_oct) begin
          do_fail = 1'b1;
        end else begin
          escv_step = {escv[5:0], hv[2:0]};
          escd_step = escd + 2'd1;
          escv_next = escv_step;
          escd_next = escd_step;
          if (escd_step >= 2'd3) begin
            do_str = 1'b1;
            str_ch = escv_step[7:0];
          end
        end
      end
      default: begin
        mode_next = M_IDLE;
        tlen_next = '0;
        acc_next = '0;
        neg_next = 1'b0;
        radix_next = RDX_DEC;
        escv_next = 9'd0;
        escd_next = 2'd0;
        if (is_end) begin
          bundle.ev[cnt] = EV_EOL;
          cnt = cnt + 2'd1;
        end else if (is_ws) begin
          mode_next = M_IDLE;
        end else if (char_in == CH_BSL) begin
          mode_next = M_BSLASH;
        end else if (char_in == CH_QUOTE) begin
          mode_next = M_STR;
        end else if (char_in == CH_PLUS || char_in == CH_MINUS) begin
          neg_next = char_in == CH_MINUS;
          mode_next = M_SIGN;
        end else if (is_dec) begin
          acc_next = NUM_WIDTH'(hv[3:0]);
          mode_next = (char_in == CH_ZERO) ? M_ZERO : M_NUM;
        end else begin
          mode_next = M_WORD;
          do_word = 1'b1;
        end
      end
    endcase

    // word continuation, word end, or failure on an over-long word
    if (do_word) begin
      if (is_end || is_ws) begin
        bundle.ev[cnt] = EV_WEND;
        cnt = cnt + 2'd1;
        mode_next = M_IDLE;
        tlen_next = '0;
        acc_next = '0;
        neg_next = 1'b0;
        radix_next = RDX_DEC;
        escv_next = 9'd0;
        escd_next = 2'd0;
        if (is_end) begin
          bundle.ev[cnt] = EV_EOL;
          cnt = cnt + 2'd1;
        end
      end else if (tlen_next >= TLEN_MAX) begin
        do_fail = 1'b1;
      end else begin
        tlen_next = tlen_next + TLEN_W'(1);
        bundle.ev[cnt] = EV_WCH;
        bundle.ch[cnt] = char_in;
        cnt = cnt + 2'd1;
      end
    end

    // decoded string character
    if (do_str) begin
      tlen_next = tlen + TLEN_W'(1);
      mode_next = M_STR;
      bundle.ev[cnt] = EV_SCH;
      bundle.ch[cnt] = str_ch;
      cnt = cnt + 2'd1;
    end

    // finished number or bad token
    if (do_done || do_fail) begin
      bundle.ev[cnt] = do_done ? EV_NUM : EV_BAD;
      cnt = cnt + 2'd1;
      mode_next = M_IDLE;
      tlen_next = '0;
      acc_next = '0;
      neg_next = 1'b0;
      radix_next = RDX_DEC;
      escv_next = 9'd0;
      escd_next = 2'd0;
      if (is_end) begin
        bundle.ev[cnt] = EV_EOL;
        cnt = cnt + 2'd1;
      end else if (do_fail) begin
        mode_next = M_SKIP;
      end
    end

    bundle.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      tlen  <= '0;
      acc   <= '0;
      neg   <= 1'b0;
      radix <= RDX_DEC;
      escv  <= 9'd0;
      escd  <= 2'd0;
    end else if (accept) begin
      mode  <= mode_next;
      tlen  <= tlen_next;
      acc   <= acc_next;
      neg   <= neg_next;
      radix <= radix_next;
      escv  <= escv_next;
      escd  <= escd_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/ftok_result_queue.sv -----
// two-entry queue of result bundles, drained one result per cycle while m_tready is high
`default_nettype none

module ftok_result_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire ftok_pkg::bundle_t             push_bundle,
  output logic                               full,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ftok_pkg::TDATA_W-1:0]       m_tdata,
  output logic [ftok_pkg::EVENT_W-1:0]       m_tuser,
  output logic                               m_tlast
);
  import ftok_pkg::*;

  bundle_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] idx;
  bundle_t    head;
  event_t     ev;
  logic       is_last;
  logic       take;
  logic       pop;

  assign head     = slot[rd_ptr];
  assign full     = count == 2'd2;
  assign m_tvalid = count != 2'd0;
  assign is_last  = idx == (head.count - 2'd1);
  assign take     = m_tvalid && m_tready;
  assign pop      = take && is_last;
  assign ev       = head.ev[idx];

  assign m_tuser = ev;
  assign m_tlast = is_last;
  assign m_tdata = {(ev == EV_NUM) ? head.num : {NUM_OUT_W{1'b0}}, head.ch[idx]};

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      idx    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
      if (take) idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

// ----- design/forth_style_tokenizer.sv -----
// Forth-style line tokenizer: takes one text byte per cycle on the s_ side
// and returns zero to three result events per byte on the m_ side, one event
// per cycle, and a byte's events are registered in the result queue before
// the first is offered. The lexer updates its state in the cycle a byte is
// accepted and files that byte's events as one bundle into a two-entry
// result queue; s_tready drops only while both entries are occupied, so the
// input sustains one byte per cycle whenever each byte yields at most one
// event and the output is not stalled. In a steady stream, a byte that yields
// two or three events can hold the input while the queue drains its bundle.
`default_nettype none

module forth_style_tokenizer #(
  parameter int MAX_TOKEN_LEN = 32,
  parameter int NUM_WIDTH     = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,  // char_in
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [ftok_pkg::TDATA_W-1:0]       m_tdata,  // char_out, number_value
  output logic [ftok_pkg::EVENT_W-1:0]       m_tuser,  // event_res
  output logic                               m_tlast   // last
);
  import ftok_pkg::*;

  bundle_t bundle;
  logic    accept;
  logic    full;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  ftok_lexer #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
    .NUM_WIDTH(NUM_WIDTH)
  ) u_lexer (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .char_in(s_tdata),
    .bundle(bundle)
  );

  ftok_result_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(accept && bundle.count != 2'd0),
    .push_bundle(bundle),
    .full(full),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

endmodule

`default_nettype wire

// ----- design/ftok_checker.sv -----
// port-level checks for the tokenizer and their attachment to the top level
`default_nettype none
`include "assert_macros.svh"

module ftok_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [ftok_pkg::TDATA_W-1:0]  m_tdata,
  input wire logic [ftok_pkg::EVENT_W-1:0]  m_tuser,
  input wire logic                          m_tlast
);
  import ftok_pkg::*;

  // a stalled result stays offered
  `FT_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // end of line always closes the events of a byte
  `FT_ASSERT_SAME(a_eol_last, clk, rst, m_tvalid && m_tuser == EV_EOL, m_tlast)
  // a number value only travels with a number event
  `FT_ASSERT_SAME(a_num_zero, clk, rst, m_tvalid && m_tuser != EV_NUM,
    m_tdata[TDATA_W-1:CHAR_W] == '0)
  // a character only travels with a character event
  `FT_ASSERT_SAME(a_char_zero, clk, rst, m_tvalid && m_tuser != EV_WCH && m_tuser != EV_SCH,
    m_tdata[CHAR_W-1:0] == '0)

endmodule

bind forth_style_tokenizer ftok_checker u_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tuser(m_tuser),
  .m_tlast(m_tlast)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// testbench for the tokenizer: text lines go in byte by byte, and each event is checked
`timescale 1ns / 1ps

module tb_top;
  import ftok_pkg::*;

  localparam int MAX_TOKEN_LEN   = 32;
  localparam int WATCHDOG_CYCLES = 1000;
  localparam int DRAIN_CYCLES    = 8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef enum logic [3:0] {
    LX_IDLE, LX_SKIP, LX_BSLASH, LX_SIGN, LX_ZERO, LX_ZEROX, LX_NUM,
    LX_WORD, LX_STR, LX_STRQ, LX_ESC, LX_ESCHEX, LX_ESCOCT
  } lex_state_t;

  typedef enum logic [1:0] {RDX_DEC, RDX_OCT, RDX_HEX} radix_t;

  typedef struct {
    event_t      ev;
    logic [7:0]  ch;
    logic [31:0] num;
    logic        last;
  } tok_event_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;
  logic [EVENT_W-1:0]  m_tuser;
  logic                m_tlast;

  // lexer copy
  lex_state_t  lx_state;
  int unsigned tok_len;
  logic [31:0] acc;
  logic        neg;
  radix_t      rdx;
  logic [8:0]  esc_val;
  int          esc_cnt;

  tok_event_t  step_q[$];
  tok_event_t  expected_q[$];
  logic [7:0]  byte_q[$];

  int src_gap_max;
  int sink_gap_max;
  int chars_sent;
  int failures;
  int idle_cycles;

  forth_style_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c inside {8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B};
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (is_digit(c)) return int'(c - CH_ZERO);
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic int radix_digit(logic [7:0] c, radix_t r);
    int d;
    int base;
    d = hex_digit(c);
    base = (r == RDX_HEX) ? 16 : (r == RDX_OCT) ? 8 : 10;
    if (d < 0 || d >= base) return -1;
    return d;
  endfunction

  function automatic int escape_char(logic [7:0] c);
    case (c)
      "a": return 7;
      "b": return 8;
      "f": return 12;
      "n": return 10;
      "r": return 13;
      "t": return 9;
      "v": return 11;
      CH_BSLASH, "'", CH_QUOTE, "?": return int'(c);
      default: return -1;
    endcase
  endfunction

  function automatic void add_event(event_t ev, logic [7:0] ch, logic [31:0] num);
    tok_event_t r;
    r.ev   = ev;
    r.ch   = ch;
    r.num  = num;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void clear_token();
    lx_state = LX_IDLE;
    tok_len  = 0;
    acc      = '0;
    neg      = 1'b0;
    rdx      = RDX_DEC;
    esc_val  = '0;
    esc_cnt  = 0;
  endfunction

  function automatic void flag_invalid(logic [7:0] c);
    add_event(EV_BAD, 8'h00, 32'h0);
    clear_token();
    if (c == CH_NUL) add_event(EV_EOL, 8'h00, 32'h0);
    else lx_state = LX_SKIP;
  endfunction

  function automatic void finish_number(logic [7:0] c);
    logic [31:0] v;
    v = neg ? -acc : acc;
    add_event(EV_NUM, 8'h00, v);
    clear_token();
    if (c == CH_NUL) add_event(EV_EOL, 8'h00, 32'h0);
  endfunction

  function automatic void word_char(logic [7:0] c);
    if (c == CH_NUL || is_blank(c)) begin
      add_event(EV_WEND, 8'h00, 32'h0);
      clear_token();
      if (c == CH_NUL) add_event(EV_EOL, 8'h00, 32'h0);
    end else if (tok_len >= MAX_TOKEN_LEN) begin
      flag_invalid(c);
    end else begin
      tok_len++;
      add_event(EV_WCH, c, 32'h0);
    end
  endfunction

  function automatic void string_char(logic [7:0] ch);
    tok_len++;
    lx_state = LX_STR;
    add_event(EV_SCH, ch, 32'h0);
  endfunction

  function automatic void start_number(logic [7:0] c);
    acc      = 32'(c - CH_ZERO);
    rdx      = RDX_DEC;
    lx_state = (c == CH_ZERO) ? LX_ZERO : LX_NUM;
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    int d;
    case (lx_state)
      LX_SKIP: begin
        if (c == CH_NUL) begin
          clear_token();
          add_event(EV_EOL, 8'h00, 32'h0);
        end
      end
      LX_BSLASH: begin
        if (c == CH_SPACE) begin
          lx_state = LX_SKIP;
        end else begin
          add_event(EV_WCH, CH_BSLASH, 32'h0);
          lx_state = LX_WORD;
          tok_len  = 1;
          word_char(c);
        end
      end
      LX_SIGN: begin
        if (is_digit(c)) begin
          start_number(c);
        end else begin
          add_event(EV_WCH, neg ? CH_MINUS : CH_PLUS, 32'h0);
          neg      = 1'b0;
          lx_state = LX_WORD;
          tok_len  = 1;
          word_char(c);
        end
      end
      LX_ZERO: begin
        if (c == CH_X) begin
          lx_state = LX_ZEROX;
        end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
          rdx      = RDX_OCT;
          acc      = 32'(c - CH_ZERO);
          lx_state = LX_NUM;
        end else if (c == CH_NUL || is_blank(c)) begin
          finish_number(c);
        end else begin
          flag_invalid(c);
        end
      end
      LX_ZEROX: begin
        d = hex_digit(c);
        if (d < 0) begin
          flag_invalid(c);
        end else begin
          rdx      = RDX_HEX;
          acc      = 32'(d);
          lx_state = LX_NUM;
        end
      end
      LX_NUM: begin
        if (c == CH_NUL || is_blank(c)) begin
          finish_number(c);
        end else begin
          d = radix_digit(c, rdx);
          if (d < 0) flag_invalid(c);
          else acc = acc * ((rdx == RDX_HEX) ? 16 : (rdx == RDX_OCT) ? 8 : 10) + d;
        end
      end
      LX_WORD: word_char(c);
      LX_STR: begin
        if (c == CH_QUOTE) lx_state = LX_STRQ;
        else if (c == CH_NUL || tok_len >= MAX_TOKEN_LEN) flag_invalid(c);
        else if (c == CH_BSLASH) lx_state = LX_ESC;
        else string_char(c);
      end
      LX_STRQ: begin
        if (c == CH_NUL || is_blank(c)) begin
          add_event(EV_SEND, 8'h00, 32'h0);
          clear_token();
          if (c == CH_NUL) add_event(EV_EOL, 8'h00, 32'h0);
        end else begin
          flag_invalid(c);
        end
      end
      LX_ESC: begin
        d = escape_char(c);
        if (c == CH_X) begin
          esc_val  = '0;
          esc_cnt  = 0;
          lx_state = LX_ESCHEX;
        end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
          esc_val  = 9'(c - CH_ZERO);
          esc_cnt  = 1;
          lx_state = LX_ESCOCT;
        end else if (d >= 0) begin
          string_char(8'(d));
        end else begin
          flag_invalid(c);
        end
      end
      LX_ESCHEX: begin
        d = hex_digit(c);
        if (d < 0) begin
          flag_invalid(c);
        end else begin
          esc_val = 9'((esc_val << 4) | d);
          esc_cnt++;
          if (esc_cnt >= 2) string_char(esc_val[7:0]);
        end
      end
      LX_ESCOCT: begin
        if (c < CH_ZERO || c > CH_SEVEN) begin
          flag_invalid(c);
        end else begin
          esc_val = 9'((esc_val << 3) | (c - CH_ZERO));
          esc_cnt++;
          if (esc_cnt >= 3) string_char(esc_val[7:0]);
        end
      end
      default: begin
        clear_token();
        if (c == CH_NUL) begin
          add_event(EV_EOL, 8'h00, 32'h0);
        end else if (is_blank(c)) begin
        end else if (c == CH_BSLASH) begin
          lx_state = LX_BSLASH;
        end else if (c == CH_QUOTE) begin
          lx_state = LX_STR;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg      = (c == CH_MINUS);
          lx_state = LX_SIGN;
        end else if (is_digit(c)) begin
          start_number(c);
        end else begin
          lx_state = LX_WORD;
          word_char(c);
        end
      end
    endcase
  endfunction

  function automatic void predict_events(logic [7:0] c);
    step_q.delete();
    lex_byte(c);
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  // text generation
  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return 8'h0C;
      1: return 8'h0A;
      2: return 8'h0D;
      3: return 8'h09;
      4: return 8'h0B;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_solid();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_blank(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) byte_q.push_back(s[i]);
  endfunction

  function automatic void add_number();
    int count;
    if ($urandom_range(0, 2) == 0) byte_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    case ($urandom_range(0, 2))
      0: begin
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 4);
        byte_q.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
        repeat (count - 1) byte_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      1: begin
        byte_q.push_back(CH_ZERO);
        repeat ($urandom_range(0, 12)) byte_q.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
      end
      default: begin
        byte_q.push_back(CH_ZERO);
        byte_q.push_back(CH_X);
        count = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 10);
        repeat (count) byte_q.push_back(pick_hex());
      end
    endcase
    if ($urandom_range(0, 7) == 0) byte_q.push_back(pick_solid());
  endfunction

  function automatic void add_word();
    logic [7:0] c;
    int count;
    case ($urandom_range(0, 5))
      0: byte_q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
      1: byte_q.push_back(CH_BSLASH);
      default: begin
        do c = pick_solid();
        while (is_digit(c) || c inside {CH_PLUS, CH_MINUS, CH_BSLASH, CH_QUOTE});
        byte_q.push_back(c);
      end
    endcase
    count = ($urandom_range(0, 11) == 0) ? $urandom_range(31, 33) : $urandom_range(0, 7);
    repeat (count) byte_q.push_back(pick_solid());
  endfunction

  function automatic void add_string();
    string singles;
    logic [7:0] c;
    int count;
    singles = "abfnrtv\\'\"?";
    byte_q.push_back(CH_QUOTE);
    count = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 33) : $urandom_range(0, 5);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          byte_q.push_back(CH_BSLASH);
          byte_q.push_back(singles[$urandom_range(0, singles.len() - 1)]);
        end
        1: begin
          byte_q.push_back(CH_BSLASH);
          byte_q.push_back(CH_X);
          byte_q.push_back(pick_hex());
          byte_q.push_back(pick_hex());
        end
        2: begin
          byte_q.push_back(CH_BSLASH);
          repeat (3) byte_q.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
        end
        default: begin
          do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
          byte_q.push_back(c);
        end
      endcase
    end
    if ($urandom_range(0, 15) == 0) begin
      byte_q.push_back(CH_BSLASH);
      byte_q.push_back($urandom_range(0, 1) ? 8'h7A : CH_X);
      byte_q.push_back(8'h67);
    end
    if ($urandom_range(0, 9) != 0) byte_q.push_back(CH_QUOTE);
    if ($urandom_range(0, 7) == 0) byte_q.push_back(pick_solid());
  endfunction

  function automatic void build_line(int num_w, int str_w, int word_w);
    int tokens;
    int pick;
    tokens = $urandom_range(1, 4);
    if ($urandom_range(0, 1) == 0) byte_q.push_back(pick_blank());
    for (int i = 0; i < tokens; i++) begin
      pick = $urandom_range(0, num_w + str_w + word_w - 1);
      if (pick < num_w) add_number();
      else if (pick < num_w + str_w) add_string();
      else add_word();
      if (i < tokens - 1 || $urandom_range(0, 1) == 0) begin
        byte_q.push_back(pick_blank());
        if ($urandom_range(0, 3) == 0) byte_q.push_back(pick_blank());
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      byte_q.push_back(CH_BSLASH);
      byte_q.push_back(CH_SPACE);
      repeat ($urandom_range(0, 4)) byte_q.push_back(8'($urandom_range(1, 255)));
    end
    byte_q.push_back(CH_NUL);
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    predict_events(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_queued();
    foreach (byte_q[i]) send_char(byte_q[i]);
    byte_q.delete();
  endtask

  task automatic run_lines(int num_w, int str_w, int word_w, int target);
    int start;
    start = chars_sent;
    while (chars_sent - start < target) begin
      build_line(num_w, str_w, word_w);
      send_queued();
    end
  endtask

  task automatic test_directed();
    src_gap_max  = 3;
    sink_gap_max = 3;
    push_text("-9 0x1F +a \\q \"\\x4A\\777\"z");
    byte_q.push_back(CH_NUL);
    push_text("08");
    byte_q.push_back(CH_NUL);
    byte_q.push_back(8'hFF);
    push_text(" \\ c");
    byte_q.push_back(CH_NUL);
    send_queued();
  endtask

  task automatic test_numbers();
    src_gap_max  = 0;
    sink_gap_max = 0;
    run_lines(6, 1, 1, 55);
  endtask

  task automatic test_strings();
    src_gap_max  = 12;
    sink_gap_max = 12;
    run_lines(1, 6, 1, 55);
  endtask

  task automatic test_words();
    src_gap_max  = 0;
    sink_gap_max = 12;
    run_lines(1, 1, 6, 45);
  endtask

  task automatic test_noise();
    string specials;
    specials = "\"\\+-0x7 9";
    src_gap_max  = 12;
    sink_gap_max = 0;
    repeat (50) begin
      case ($urandom_range(0, 9))
        0: byte_q.push_back(CH_NUL);
        1: byte_q.push_back(pick_blank());
        2, 3, 4: byte_q.push_back(specials[$urandom_range(0, specials.len() - 1)]);
        default: byte_q.push_back(8'($urandom_range(1, 255)));
      endcase
    end
    byte_q.push_back(CH_NUL);
    send_queued();
  endtask

  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      int hold;
      hold = $urandom_range(0, sink_gap_max);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (rst || !(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    tok_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: event_res %0d", m_tuser);
        failures++;
      end else begin
        want = expected_q.pop_front();
        if (m_tuser !== want.ev) begin
          $error("event_res mismatch: expected %0d, actual %0d", want.ev, m_tuser);
          failures++;
        end
        if (m_tdata[7:0] !== want.ch) begin
          $error("char_out mismatch: expected %0h, actual %0h", want.ch, m_tdata[7:0]);
          failures++;
        end
        if (m_tdata[39:8] !== want.num) begin
          $error("number_value mismatch: expected %0d, actual %0d",
                 $signed(want.num), $signed(m_tdata[39:8]));
          failures++;
        end
        if (m_tlast !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, m_tlast);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("[forth_style_tokenizer] ERROR");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    src_gap_max  = 0;
    sink_gap_max = 0;
    chars_sent   = 0;
    failures     = 0;
    idle_cycles  = 0;
    clear_token();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_numbers();
    test_strings();
    test_words();
    test_noise();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[forth_style_tokenizer] OK");
    end else begin
      $display("[forth_style_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
